// ===== sv/gmsig_pkg.sv =====
// Shared types and constants for the stitched grid triangle index generator.
// Holds the walk phase enum, the walk position struct and the register codes.
// No dependencies.
package gmsig_pkg;

  // Largest supported vertices per grid side
  localparam logic [7:0] MAX_GRID_SIZE = 8'd255;

  // Configuration register indexes
  localparam logic CFG_GRID_SIZE = 1'b0;
  localparam logic CFG_EDGE_MODE = 1'b1;

  // Edge stitching modes
  localparam logic [3:0] EDGE_NONE         = 4'd0;
  localparam logic [3:0] EDGE_TOP          = 4'd1;
  localparam logic [3:0] EDGE_BOTTOM       = 4'd2;
  localparam logic [3:0] EDGE_RIGHT        = 4'd3;
  localparam logic [3:0] EDGE_LEFT         = 4'd4;
  localparam logic [3:0] EDGE_TOP_RIGHT    = 4'd5;
  localparam logic [3:0] EDGE_RIGHT_BOTTOM = 4'd6;
  localparam logic [3:0] EDGE_BOTTOM_LEFT  = 4'd7;
  localparam logic [3:0] EDGE_LEFT_TOP     = 4'd8;

  typedef enum logic [1:0] {
    PH_DONE,
    PH_BASE,
    PH_FAN_TB,
    PH_FAN_LR
  } phase_e;

  // Position of the walk: phase, cell, triangle half and fan slot
  typedef struct packed {
    phase_e     phase;
    logic [7:0] col;
    logic [7:0] row;
    logic       half;
    logic [7:0] fan;
  } walk_t;

  // Stitched edges decoded from the edge mode
  typedef struct packed {
    logic top;
    logic bottom;
    logic right;
    logic left;
  } edge_t;

  // Outcome of a short scan along one row of cells
  typedef struct packed {
    logic       found;
    logic [7:0] col;
    logic       half;
  } scan_t;

  function automatic edge_t edge_decode(logic [3:0] mode);
    edge_t e;
    e.top    = mode inside {EDGE_TOP, EDGE_TOP_RIGHT, EDGE_LEFT_TOP};
    e.bottom = mode inside {EDGE_BOTTOM, EDGE_RIGHT_BOTTOM, EDGE_BOTTOM_LEFT};
    e.right  = mode inside {EDGE_RIGHT, EDGE_TOP_RIGHT, EDGE_RIGHT_BOTTOM};
    e.left   = mode inside {EDGE_LEFT, EDGE_BOTTOM_LEFT, EDGE_LEFT_TOP};
    return e;
  endfunction

endpackage

// ===== sv/grid_mesh_stitch_index_generator.sv =====
// A request accepted at one edge has its triangle in the output register at that
// edge; it is visible on the outputs in the next cycle. Throughput: one request,
// and one triangle, per cycle while in_ready_o is high; the walk position is held
// settled on the next triangle to emit, so no request is spent on dropped triangles.
// A configuration write blocks requests for the following cycle (start point refresh).
// Reset: walk done, grid_size 41, edge_mode none, output register empty.
// Depends on gmsig_pkg.
module grid_mesh_stitch_index_generator (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration write port
  input  logic        cfg_we_i,
  input  logic        cfg_index_i,
  input  logic [7:0]  cfg_data_i,
  // request channel
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        start_req_i,
  // result channel
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [15:0] vert_a_o,
  output logic [15:0] vert_b_o,
  output logic [15:0] vert_c_o,
  output logic        tri_valid_o,
  output logic        tri_last_o
);

  // Drop rule for one base triangle at column x, row y, half h
  function automatic logic is_dropped(logic [7:0] n, logic [8:0] x, logic [8:0] y,
                                      logic h, gmsig_pkg::edge_t e);
    logic side_rule;
    logic drop;
    side_rule = (h != y[0]);
    drop      = 1'b0;
    if (e.top && !h && (y == 9'd0)) drop = 1'b1;
    if (e.bottom && h && (({1'b0, y} + 10'd2) == {2'b00, n})) drop = 1'b1;
    if (e.right && (({1'b0, x} + 10'd2) == {2'b00, n}) && side_rule) drop = 1'b1;
    if (e.left && (x == 9'd0) && side_rule) drop = 1'b1;
    return drop;
  endfunction

  // Look at four successive triangles of a row; a row never drops more than three
  // in a row, so the first kept one is among them unless the row ends first
  function automatic gmsig_pkg::scan_t scan_row(logic [7:0] n, logic [7:0] cells,
                                                logic [8:0] row, logic [8:0] col,
                                                logic half, gmsig_pkg::edge_t e);
    gmsig_pkg::scan_t s;
    logic [9:0]       t0;
    logic [9:0]       t;
    logic             stop;
    s    = '0;
    stop = 1'b0;
    t0   = {col, half};
    for (int k = 0; k < 4; k++) begin
      t = t0 + 10'(k);
      if (!stop) begin
        if (t[9:1] >= {1'b0, cells}) begin
          stop = 1'b1;
        end else if (!is_dropped(n, t[9:1], row, t[0], e)) begin
          stop    = 1'b1;
          s.found = 1'b1;
          s.col   = t[8:1];
          s.half  = t[0];
        end
      end
    end
    return s;
  endfunction

  // Move the walk on to the next triangle to emit, or to done
  function automatic gmsig_pkg::walk_t settle_walk(gmsig_pkg::walk_t p, logic [7:0] n,
                                                   logic [7:0] cells, logic [6:0] fans,
                                                   gmsig_pkg::edge_t e);
    gmsig_pkg::walk_t w;
    gmsig_pkg::scan_t s1;
    gmsig_pkg::scan_t s2;
    logic [8:0]       row1;
    logic [8:0]       row2;
    logic [8:0]       col1;
    logic             half1;
    logic             go_fan;
    w      = p;
    go_fan = 1'b0;
    row1   = {1'b0, p.row};
    col1   = {1'b0, p.col};
    half1  = p.half;
    // wrap a column past the row end onto the next row
    if (p.col >= cells) begin
      row1  = row1 + 9'd1;
      col1  = '0;
      half1 = 1'b0;
    end
    row2 = row1 + 9'd1;
    s1   = scan_row(n, cells, row1, col1, half1, e);
    s2   = scan_row(n, cells, row2, 9'd0, 1'b0, e);
    if (p.phase == gmsig_pkg::PH_BASE) begin
      if ((p.row >= cells) || (row1 >= {1'b0, cells})) begin
        go_fan = 1'b1;
      end else if (s1.found) begin
        w.row  = row1[7:0];
        w.col  = s1.col;
        w.half = s1.half;
      end else if (row2 >= {1'b0, cells}) begin
        go_fan = 1'b1;
      end else if (s2.found) begin
        w.row  = row2[7:0];
        w.col  = s2.col;
        w.half = s2.half;
      end else begin
        go_fan = 1'b1;
      end
    end
    if (go_fan) begin
      w.phase = gmsig_pkg::PH_FAN_TB;
      w.fan   = '0;
    end
    if ((w.phase == gmsig_pkg::PH_FAN_TB) &&
        (!(e.top || e.bottom) || (w.fan >= {1'b0, fans}))) begin
      w.phase = gmsig_pkg::PH_FAN_LR;
      w.fan   = '0;
    end
    if ((w.phase == gmsig_pkg::PH_FAN_LR) &&
        (!(e.left || e.right) || (w.fan >= {1'b0, fans}))) begin
      w.phase = gmsig_pkg::PH_DONE;
      w.fan   = '0;
    end
    return w;
  endfunction

  // Advance past the triangle just emitted
  function automatic gmsig_pkg::walk_t step_walk(gmsig_pkg::walk_t p);
    gmsig_pkg::walk_t w;
    w = p;
    if (p.phase == gmsig_pkg::PH_BASE) begin
      if (!p.half) begin
        w.half = 1'b1;
      end else begin
        w.half = 1'b0;
        w.col  = p.col + 8'd1;
      end
    end else begin
      w.fan = p.fan + 8'd1;
    end
    return w;
  endfunction

  logic [7:0]       grid_q;
  logic [3:0]       mode_q;
  logic             cfg_hold_q;
  gmsig_pkg::walk_t walk_q, walk_d;
  gmsig_pkg::walk_t start_q, start_d;
  logic             out_valid_q, out_valid_d;
  logic [15:0]      vert_a_q, vert_a_d;
  logic [15:0]      vert_b_q, vert_b_d;
  logic [15:0]      vert_c_q, vert_c_d;
  logic             tri_valid_q, tri_valid_d;
  logic             tri_last_q, tri_last_d;

  logic [7:0]       n;
  logic [7:0]       cells;
  logic [6:0]       fans;
  gmsig_pkg::edge_t edges;
  gmsig_pkg::walk_t pos;
  gmsig_pkg::walk_t next_pos;
  gmsig_pkg::walk_t init_pos;
  logic             in_acc;
  logic             out_acc;
  logic             emit;
  logic [8:0]       mul_op;
  logic [16:0]      prod;
  logic [15:0]      p16;
  logic [15:0]      n16;
  logic [15:0]      cell_a;
  logic [15:0]      fan_x;
  logic [15:0]      va, vb, vc;

  // Decode the live configuration
  assign n     = (grid_q > gmsig_pkg::MAX_GRID_SIZE) ? gmsig_pkg::MAX_GRID_SIZE : grid_q;
  assign cells = (n >= 8'd2) ? (n - 8'd1) : 8'd0;
  assign fans  = (n >= 8'd3) ? 7'((n - 8'd1) >> 1) : 7'd0;
  assign edges = gmsig_pkg::edge_decode(mode_q);

  // Handshakes
  assign in_ready_o = !cfg_hold_q && (!out_valid_q || out_ready_i);
  assign in_acc     = in_valid_i && in_ready_o;
  assign out_acc    = out_valid_q && out_ready_i;

  // Settled first triangle of a fresh walk, refreshed every cycle
  always_comb begin
    init_pos       = '0;
    init_pos.phase = gmsig_pkg::PH_BASE;
    start_d        = settle_walk(init_pos, n, cells, fans, edges);
  end

  // Pick the walk position for this request and work out the following one
  assign pos      = start_req_i ? start_q : walk_q;
  assign emit     = (pos.phase != gmsig_pkg::PH_DONE);
  assign next_pos = settle_walk(step_walk(pos), n, cells, fans, edges);

  // Shared multiplier: row base, grid area or fan row base by phase
  always_comb begin
    case (pos.phase)
      gmsig_pkg::PH_BASE:   mul_op = {1'b0, pos.row};
      gmsig_pkg::PH_FAN_TB: mul_op = {1'b0, n};
      gmsig_pkg::PH_FAN_LR: mul_op = {pos.fan, 1'b0};
      default:              mul_op = '0;
    endcase
  end

  assign prod   = 17'(mul_op) * 17'(n);
  assign p16    = prod[15:0];
  assign n16    = {8'd0, n};
  assign cell_a = p16 + {8'd0, pos.col};
  assign fan_x  = {7'd0, pos.fan, 1'b0};

  // Form the triangle's three vertex indices
  always_comb begin
    va = '0;
    vb = '0;
    vc = '0;
    case (pos.phase)
      gmsig_pkg::PH_BASE: begin
        if (!cell_a[0]) begin
          if (!pos.half) begin
            va = cell_a;
            vb = cell_a + 16'd1;
            vc = cell_a + n16 + 16'd1;
          end else begin
            va = cell_a + n16 + 16'd1;
            vb = cell_a + n16;
            vc = cell_a;
          end
        end else begin
          if (!pos.half) begin
            va = cell_a;
            vb = cell_a + 16'd1;
            vc = cell_a + n16;
          end else begin
            va = cell_a + 16'd1;
            vb = cell_a + n16 + 16'd1;
            vc = cell_a + n16;
          end
        end
      end
      gmsig_pkg::PH_FAN_TB: begin
        if (edges.top) begin
          va = fan_x;
          vb = fan_x + 16'd2;
          vc = fan_x + n16 + 16'd1;
        end else begin
          // last row starts at n*n - n, the one above at n*n - 2n
          va = fan_x + p16 - n16;
          vb = fan_x + p16 - n16 + 16'd2;
          vc = fan_x + p16 - (n16 << 1) + 16'd1;
        end
      end
      gmsig_pkg::PH_FAN_LR: begin
        if (edges.right) begin
          va = n16 - 16'd1 + p16;
          vb = n16 - 16'd1 + p16 + (n16 << 1);
          vc = n16 - 16'd2 + p16 + n16;
        end else begin
          va = p16;
          vb = p16 + (n16 << 1);
          vc = 16'd1 + p16 + n16;
        end
      end
      default: begin
        va = '0;
        vb = '0;
        vc = '0;
      end
    endcase
  end

  // Next walk position and output register contents
  always_comb begin
    walk_d      = walk_q;
    out_valid_d = out_valid_q;
    vert_a_d    = vert_a_q;
    vert_b_d    = vert_b_q;
    vert_c_d    = vert_c_q;
    tri_valid_d = tri_valid_q;
    tri_last_d  = tri_last_q;
    if (out_acc) begin
      out_valid_d = 1'b0;
    end
    if (in_acc) begin
      walk_d      = emit ? next_pos : pos;
      out_valid_d = 1'b1;
      vert_a_d    = emit ? va : 16'd0;
      vert_b_d    = emit ? vb : 16'd0;
      vert_c_d    = emit ? vc : 16'd0;
      tri_valid_d = emit;
      tri_last_d  = emit && (next_pos.phase == gmsig_pkg::PH_DONE);
    end
  end

  // Configuration registers; a write holds off requests in the next cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_q     <= 8'd41;
      mode_q     <= gmsig_pkg::EDGE_NONE;
      cfg_hold_q <= 1'b1;
    end else begin
      cfg_hold_q <= cfg_we_i;
      if (cfg_we_i) begin
        case (cfg_index_i)
          gmsig_pkg::CFG_GRID_SIZE: grid_q <= cfg_data_i;
          gmsig_pkg::CFG_EDGE_MODE: mode_q <= cfg_data_i[3:0];
          default: ;
        endcase
      end
    end
  end

  // Walk state and start point
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      walk_q      <= '0;
      start_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      walk_q      <= walk_d;
      start_q     <= start_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    vert_a_q    <= vert_a_d;
    vert_b_q    <= vert_b_d;
    vert_c_q    <= vert_c_d;
    tri_valid_q <= tri_valid_d;
    tri_last_q  <= tri_last_d;
  end

  assign out_valid_o = out_valid_q;
  assign vert_a_o    = vert_a_q;
  assign vert_b_o    = vert_b_q;
  assign vert_c_o    = vert_c_q;
  assign tri_valid_o = tri_valid_q;
  assign tri_last_o  = tri_last_q;

  // A configuration write blocks requests in the next cycle
  a_cfg_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i |=> !in_ready_o)
    else $error("request taken right after a configuration write");

  // A last flag only comes with a real triangle
  a_last_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && tri_last_o |-> tri_valid_o)
    else $error("last flag without a triangle");

  // The walk is done after its last triangle
  a_last_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && tri_last_d |=> (walk_q.phase == gmsig_pkg::PH_DONE))
    else $error("walk still running after last triangle");

  // Every accepted request leaves a result behind
  a_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> out_valid_o)
    else $error("accepted request produced no result");

endmodule

// ===== tb/sv/stitch_list_checker.sv =====
`timescale 1ns / 1ps
// Checker for the stitched grid triangle index generator: tracks config writes and requests,
// predicts each triangle of the index list and compares it with the result channel.
// Depends on gmsig_pkg.
module stitch_list_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_index_i,
  input  logic [7:0]  cfg_data_i,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic        start_req_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [15:0] vert_a_i,
  input  logic [15:0] vert_b_i,
  input  logic [15:0] vert_c_i,
  input  logic        tri_valid_i,
  input  logic        tri_last_i,
  output int          error_count_o,
  output int          pending_o
);

  typedef struct packed {
    logic [15:0] a;
    logic [15:0] b;
    logic [15:0] c;
    logic        valid;
    logic        last;
  } triangle_t;

  // Shadow copy of the registers and the walk position
  logic [7:0]       side_reg;
  logic [3:0]       mode_reg;
  gmsig_pkg::walk_t pos;
  triangle_t        expected_tris[$];
  int               mismatch_count;

  function automatic gmsig_pkg::edge_t stitched_edges(input logic [3:0] mode);
    gmsig_pkg::edge_t e;
    e = '0;
    case (mode)
      gmsig_pkg::EDGE_TOP:          e.top = 1'b1;
      gmsig_pkg::EDGE_BOTTOM:       e.bottom = 1'b1;
      gmsig_pkg::EDGE_RIGHT:        e.right = 1'b1;
      gmsig_pkg::EDGE_LEFT:         e.left = 1'b1;
      gmsig_pkg::EDGE_TOP_RIGHT: begin
        e.top   = 1'b1;
        e.right = 1'b1;
      end
      gmsig_pkg::EDGE_RIGHT_BOTTOM: begin
        e.right  = 1'b1;
        e.bottom = 1'b1;
      end
      gmsig_pkg::EDGE_BOTTOM_LEFT: begin
        e.bottom = 1'b1;
        e.left   = 1'b1;
      end
      gmsig_pkg::EDGE_LEFT_TOP: begin
        e.left = 1'b1;
        e.top  = 1'b1;
      end
      default: ;
    endcase
    return e;
  endfunction

  function automatic int unsigned grid_side();
    return 32'((side_reg > gmsig_pkg::MAX_GRID_SIZE) ? gmsig_pkg::MAX_GRID_SIZE : side_reg);
  endfunction

  // A side edge drops halves whose running count 2*row+half is 1 or 2 mod 4
  function automatic bit skip_half(input int unsigned n, input int unsigned x,
                                   input int unsigned y, input bit h);
    gmsig_pkg::edge_t e;
    bit               side_rule;
    e         = stitched_edges(mode_reg);
    side_rule = (h != y[0]);
    return (e.top && !h && y == 0) || (e.bottom && h && y + 2 == n) ||
           (e.right && x + 2 == n && side_rule) || (e.left && x == 0 && side_rule);
  endfunction

  function automatic void step_half();
    if (!pos.half) begin
      pos.half = 1'b1;
    end else begin
      pos.half = 1'b0;
      pos.col  = pos.col + 8'd1;
    end
  endfunction

  // Advance the walk until it points at a triangle to emit, or is done
  function automatic void settle_walk();
    int unsigned      n, cells, fans;
    gmsig_pkg::edge_t e;
    bit               moving;
    n      = grid_side();
    cells  = (n >= 2) ? n - 1 : 0;
    fans   = (n >= 3) ? (n - 1) / 2 : 0;
    e      = stitched_edges(mode_reg);
    moving = 1'b1;
    while (moving) begin
      case (pos.phase)
        gmsig_pkg::PH_BASE: begin
          if (pos.row >= cells) begin
            pos.phase = gmsig_pkg::PH_FAN_TB;
            pos.fan   = '0;
          end else if (pos.col >= cells) begin
            pos.col  = '0;
            pos.half = 1'b0;
            pos.row  = pos.row + 8'd1;
          end else if (skip_half(n, pos.col, pos.row, pos.half)) begin
            step_half();
          end else begin
            moving = 1'b0;
          end
        end
        gmsig_pkg::PH_FAN_TB: begin
          if (!(e.top || e.bottom) || pos.fan >= fans) begin
            pos.phase = gmsig_pkg::PH_FAN_LR;
            pos.fan   = '0;
          end else begin
            moving = 1'b0;
          end
        end
        gmsig_pkg::PH_FAN_LR: begin
          if (!(e.right || e.left) || pos.fan >= fans) begin
            pos.phase = gmsig_pkg::PH_DONE;
            pos.fan   = '0;
          end
          moving = 1'b0;
        end
        default: begin
          pos.phase = gmsig_pkg::PH_DONE;
          moving    = 1'b0;
        end
      endcase
    end
  endfunction

  // Work out the triangle that one request produces and move the walk on
  function automatic triangle_t walk_request(input logic restart);
    triangle_t        t;
    int unsigned      n, a, x, y, v0, v1, v2;
    gmsig_pkg::edge_t e;
    t  = '0;
    v0 = 0;
    v1 = 0;
    v2 = 0;
    if (restart) begin
      pos       = '0;
      pos.phase = gmsig_pkg::PH_BASE;
      settle_walk();
    end
    if (pos.phase != gmsig_pkg::PH_DONE) begin
      n = grid_side();
      e = stitched_edges(mode_reg);
      case (pos.phase)
        gmsig_pkg::PH_BASE: begin
          a = pos.row * n + pos.col;
          // diagonal direction follows the parity of the cell's first vertex
          if (!a[0]) begin
            if (!pos.half) begin
              v0 = a;  v1 = a + 1;  v2 = a + n + 1;
            end else begin
              v0 = a + n + 1;  v1 = a + n;  v2 = a;
            end
          end else begin
            if (!pos.half) begin
              v0 = a;  v1 = a + 1;  v2 = a + n;
            end else begin
              v0 = a + 1;  v1 = a + n + 1;  v2 = a + n;
            end
          end
        end
        gmsig_pkg::PH_FAN_TB: begin
          x = 2 * pos.fan;
          if (e.top) begin
            v0 = x;  v1 = x + 2;  v2 = x + n + 1;
          end else begin
            v0 = x + (n - 1) * n;
            v1 = x + (n - 1) * n + 2;
            v2 = x + (n - 2) * n + 1;
          end
        end
        default: begin
          y = 2 * pos.fan;
          if (e.right) begin
            x  = n - 1;
            v0 = x + y * n;
            v1 = x + (y + 2) * n;
            v2 = (x - 1) + (y + 1) * n;
          end else begin
            v0 = y * n;
            v1 = (y + 2) * n;
            v2 = 1 + (y + 1) * n;
          end
        end
      endcase
      t.valid = 1'b1;
      if (pos.phase == gmsig_pkg::PH_BASE) begin
        step_half();
      end else begin
        pos.fan = pos.fan + 8'd1;
      end
      settle_walk();
      t.last = (pos.phase == gmsig_pkg::PH_DONE);
    end
    t.a = v0[15:0];
    t.b = v1[15:0];
    t.c = v2[15:0];
    return t;
  endfunction

  // Compare results first, then take config writes, then queue new requests
  always @(posedge clk_i or negedge rst_ni) begin : track_list
    triangle_t got, want, next_tri;
    if (!rst_ni) begin
      side_reg       = 8'd41;
      mode_reg       = gmsig_pkg::EDGE_NONE;
      pos            = '0;
      pos.phase      = gmsig_pkg::PH_DONE;
      mismatch_count = 0;
      expected_tris.delete();
    end else begin
      if (out_valid_i && out_ready_i) begin
        got = {vert_a_i, vert_b_i, vert_c_i, tri_valid_i, tri_last_i};
        if (expected_tris.size() == 0) begin
          if (mismatch_count < 10)
            $display("%0t: triangle with no request pending: a=%0d b=%0d c=%0d v=%0b l=%0b",
                     $time, got.a, got.b, got.c, got.valid, got.last);
          mismatch_count++;
        end else begin
          want = expected_tris.pop_front();
          if (got !== want) begin
            if (mismatch_count < 10) begin
              $display("%0t: triangle mismatch: expected a=%0d b=%0d c=%0d valid=%0b last=%0b",
                       $time, want.a, want.b, want.c, want.valid, want.last);
              $display("%0t:                    got      a=%0d b=%0d c=%0d valid=%0b last=%0b",
                       $time, got.a, got.b, got.c, got.valid, got.last);
            end
            mismatch_count++;
          end
        end
      end
      if (cfg_we_i) begin
        if (cfg_index_i == gmsig_pkg::CFG_GRID_SIZE) begin
          side_reg = cfg_data_i;
        end else begin
          mode_reg = cfg_data_i[3:0];
        end
      end
      if (in_valid_i && in_ready_i) begin
        next_tri = walk_request(start_req_i);
        expected_tris.insert(expected_tris.size(), next_tri);
      end
    end
    pending_o     <= expected_tris.size();
    error_count_o <= mismatch_count;
  end

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps
// Top of the testbench for the stitched grid triangle index generator: clock, reset,
// request and config stimulus, result back-pressure, watchdog and verdict.
// Depends on gmsig_pkg, grid_mesh_stitch_index_generator and stitch_list_checker.
module testbench;

  localparam int         QUIET_LIMIT     = 1000;
  localparam int         RANDOM_REQUESTS = 1600;
  localparam logic [3:0] EDGE_MODE_MAX   = 4'd15;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        cfg_we_i    = 1'b0;
  logic        cfg_index_i = 1'b0;
  logic [7:0]  cfg_data_i  = '0;
  logic        in_valid_i  = 1'b0;
  logic        start_req_i = 1'b0;
  logic        out_ready_i = 1'b0;
  logic        in_ready_o;
  logic        out_valid_o;
  logic [15:0] vert_a_o;
  logic [15:0] vert_b_o;
  logic [15:0] vert_c_o;
  logic        tri_valid_o;
  logic        tri_last_o;

  int   mismatches;
  int   pending;
  int   requests_sent = 0;
  int   quiet_cycles  = 0;
  logic ready_rush    = 1'b0;
  int   ready_hold    = 0;

  grid_mesh_stitch_index_generator dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .start_req_i (start_req_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .vert_a_o    (vert_a_o),
    .vert_b_o    (vert_b_o),
    .vert_c_o    (vert_c_o),
    .tri_valid_o (tri_valid_o),
    .tri_last_o  (tri_last_o)
  );

  stitch_list_checker list_check (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_ready_i    (in_ready_o),
    .start_req_i   (start_req_i),
    .out_valid_i   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .vert_a_i      (vert_a_o),
    .vert_b_i      (vert_b_o),
    .vert_c_i      (vert_c_o),
    .tri_valid_i   (tri_valid_o),
    .tri_last_i    (tri_last_o),
    .error_count_o (mismatches),
    .pending_o     (pending)
  );

  always #5 clk_i = ~clk_i;

  // Randomly stall the result channel after accepted triangles, except in full-rate stretches
  always @(posedge clk_i or negedge rst_ni) begin : drive_ready
    int stall;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      ready_hold  <= 0;
    end else if (ready_hold != 0) begin
      ready_hold <= ready_hold - 1;
      if (ready_hold == 1) out_ready_i <= 1'b1;
    end else if (!out_ready_i) begin
      out_ready_i <= 1'b1;
    end else if (out_valid_o) begin
      // flip between stalling and full-rate stretches now and then
      if ($urandom_range(0, 49) == 0) ready_rush <= ~ready_rush;
      stall = ready_rush ? 0 : $urandom_range(0, 10);
      if (stall != 0) begin
        out_ready_i <= 1'b0;
        ready_hold  <= stall;
      end
    end
  end

  // End the run when nothing moves for too long
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || cfg_we_i) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Present one request, after a random gap unless eager, and hold it until accepted
  task automatic send_request(input logic restart, input bit eager);
    int gap;
    gap = eager ? 0 : $urandom_range(0, 10);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    start_req_i <= restart;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    requests_sent++;
  endtask

  // Drain all outstanding triangles, then write both registers
  task automatic configure(input logic [7:0] side, input logic [3:0] mode);
    logic [3:0] upper_bits;
    upper_bits = 4'($urandom);
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= gmsig_pkg::CFG_GRID_SIZE;
    cfg_data_i  <= side;
    @(posedge clk_i);
    cfg_index_i <= gmsig_pkg::CFG_EDGE_MODE;
    cfg_data_i  <= {upper_bits, mode};
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // One walk: optional config, a leading request, then mostly advance requests
  task automatic run_walk(input logic [7:0] side, input logic [3:0] mode, input int count,
                          input logic restart, input bit write_cfg, input bit eager);
    if (write_cfg) configure(side, mode);
    for (int i = 0; i < count; i++)
      send_request((i == 0) ? restart : ($urandom_range(0, 63) == 0), eager);
  endtask

  initial begin : stimulus
    int         pick;
    int         side;
    int         walk_len;
    logic [3:0] mode;

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // idle walk after reset, then a restart at the reset grid size
    send_request(1'b0, 1'b0);
    send_request(1'b1, 1'b0);
    // empty lists for degenerate grids
    run_walk(8'd0, gmsig_pkg::EDGE_NONE, 1, 1'b1, 1'b1, 1'b0);
    run_walk(8'd1, gmsig_pkg::EDGE_TOP, 1, 1'b1, 1'b1, 1'b0);
    // single cell, then one request past the end
    run_walk(8'd2, gmsig_pkg::EDGE_NONE, 3, 1'b1, 1'b1, 1'b0);
    // smallest grid with both fans
    run_walk(8'd3, gmsig_pkg::EDGE_TOP_RIGHT, 7, 1'b1, 1'b1, 1'b1);
    // undefined edge mode acts as none
    run_walk(8'd2, EDGE_MODE_MAX, 2, 1'b1, 1'b1, 1'b0);
    // largest grid, restarted mid-walk
    run_walk(gmsig_pkg::MAX_GRID_SIZE, gmsig_pkg::EDGE_LEFT_TOP, 2, 1'b1, 1'b1, 1'b0);
    send_request(1'b1, 1'b0);

    // random walks, mostly complete lists on small grids
    while (requests_sent < RANDOM_REQUESTS) begin
      pick = $urandom_range(0, 99);
      if (pick < 3) side = $urandom_range(0, 1);
      else if (pick < 80) side = $urandom_range(2, 10);
      else if (pick < 94) side = $urandom_range(11, 40);
      else side = ($urandom_range(0, 1) == 0) ? gmsig_pkg::MAX_GRID_SIZE
                                              : $urandom_range(41, 254);
      if ($urandom_range(0, 5) == 0)
        mode = 4'($urandom_range(gmsig_pkg::EDGE_LEFT_TOP + 4'd1, EDGE_MODE_MAX));
      else mode = 4'($urandom_range(gmsig_pkg::EDGE_NONE, gmsig_pkg::EDGE_LEFT_TOP));
      walk_len = (side < 2) ? 2 : 2 * (side - 1) * (side - 1) + side + 2;
      if (walk_len > 200) walk_len = $urandom_range(20, 120);
      run_walk(side[7:0], mode, walk_len, $urandom_range(0, 6) != 0,
               $urandom_range(0, 7) != 0, $urandom_range(0, 3) == 0);
    end

    // drain and settle
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (mismatches == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/gmsig_pkg.sv
sv/grid_mesh_stitch_index_generator.sv
tb/sv/stitch_list_checker.sv
tb/sv/testbench.sv
